// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MOS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mos_pkg.sv =====
// Shared constants, types and helpers of the opacity sampler.
package mos_pkg;

	localparam int ATLAS_DIM   = 512;
	localparam int DIM_W       = $clog2(ATLAS_DIM);
	localparam int DIMV_W      = $clog2(ATLAS_DIM + 1);
	localparam int ADDR_W      = 2 * DIM_W;
	localparam int STORE_DEPTH = ATLAS_DIM * ATLAS_DIM;

	localparam int IDX_W     = 18;
	localparam int CH_W      = 8;
	localparam int TEXEL_W   = 3 * CH_W;
	localparam int COORD_W   = 18;
	localparam int UCOORD_W  = 17;
	localparam int SR_W      = 24;
	localparam int PR_W      = 16;
	localparam int CFG_DIM_W = 10;
	localparam int PS_W      = PR_W + SR_W;
	localparam int OPA_W     = 16;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 16;

	// divider widths
	localparam int NUM_W = 56;
	localparam int DEN_W = 49;
	localparam int QUO_W = 15;
	localparam int CMP_W = DEN_W + QUO_W;

	localparam logic [UCOORD_W-1:0] COORD_ONE = 17'h10000;
	localparam logic [SR_W-1:0]     SR_MIN    = 24'd5;
	localparam logic [PS_W-1:0]     PS_MIN    = 40'd16778;
	localparam logic [PR_W-1:0]     PR_MIN    = 16'd4096;
	localparam logic [DEN_W-1:0]    DEN_CONST = 49'd510;
	localparam int                  NUM_A_SH  = 40;
	localparam logic [NUM_W-1:0]    NUM_B     = 56'd65536000;
	localparam logic [NUM_W-1:0]    NUM_C     = 56'd268435456000;

	typedef enum logic [1:0] {
		RNG_PS,
		RNG_CONST,
		RNG_P
	} rng_mode_t;

	typedef enum logic [1:0] {
		REG_DIST_RANGE   = 2'd0,
		REG_TEX_WIDTH    = 2'd1,
		REG_TEX_HEIGHT   = 2'd2,
		REG_ATLAS_READY  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PR_W-1:0]      dist_range;
		logic [CFG_DIM_W-1:0] width;
		logic [CFG_DIM_W-1:0] height;
		logic                 ready;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [TEXEL_W-1:0] wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic             zero;
		logic             neg;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

// ===== rtl/core/mos_store.sv =====
// Texel store: one write port, one registered read port.
module mos_store
	import mos_pkg::*;
(
	input  logic               clk,
	input  mem_req_t           req,
	output logic [TEXEL_W-1:0] rdata
);

	logic [TEXEL_W-1:0] mem_q [STORE_DEPTH];
	logic [TEXEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mos_front.sv =====
// Front pipeline: coordinate mapping, range setup, texel access, median.
`include "assert_macros.svh"
module mos_front
	import mos_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [S_TDATA_W-1:0] in_data,
	input  logic                 in_action,
	input  cfg_t                 cfg,
	output mem_req_t             mem,
	input  logic [TEXEL_W-1:0]   rdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output div_req_t             out_req
);

	function automatic logic [DIMV_W-1:0] dim_sat(input logic [CFG_DIM_W-1:0] v);
		logic [DIMV_W-1:0] r;
		if (v == '0) begin
			r = DIMV_W'(1);
		end else if (int'(v) > ATLAS_DIM) begin
			r = DIMV_W'(ATLAS_DIM);
		end else begin
			r = DIMV_W'(v);
		end
		return r;
	endfunction

	function automatic logic [UCOORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
		logic [UCOORD_W-1:0] r;
		if (c[COORD_W-1]) begin
			r = '0;
		end else if (c[UCOORD_W-1:0] > COORD_ONE) begin
			r = COORD_ONE;
		end else begin
			r = c[UCOORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [CH_W-1:0] median3(input logic [CH_W-1:0] a, b, c);
		logic [CH_W-1:0] lo, hi, t;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		t  = (hi < c) ? hi : c;
		return (lo > t) ? lo : t;
	endfunction

	// input field unpack
	logic [IDX_W-1:0]   f_idx;
	logic [TEXEL_W-1:0] f_rgb;
	logic [COORD_W-1:0] f_cx, f_cy;
	logic [SR_W-1:0]    f_sr;

	assign f_idx = in_data[17:0];
	assign f_rgb = {in_data[25:18], in_data[33:26], in_data[41:34]};
	assign f_cx  = in_data[59:42];
	assign f_cy  = in_data[77:60];
	assign f_sr  = in_data[101:78];

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic                act_s1, zero_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TEXEL_W-1:0]  rgb_s1;
	logic [UCOORD_W-1:0] cx_s1, cy_s1;
	logic [SR_W-1:0]     sr_s1;
	logic [DIMV_W-1:0]   w_s1, h_s1;

	// stage 2
	logic               act_s2, zero_s2, sge_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [TEXEL_W-1:0] rgb_s2;
	logic [DIMV_W-1:0]  w_s2;
	logic [DIM_W-1:0]   x_s2, y_s2;
	logic [PS_W-1:0]    ps_s2;
	logic [PR_W-1:0]    p_s2;

	// stage 3
	logic               act_s3, zero_s3, iok_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic [TEXEL_W-1:0] rgb_s3;
	logic [ADDR_W-1:0]  addr_s3;
	rng_mode_t          mode_s3;
	logic [DEN_W-1:0]   den_s3;

	// stage 4
	logic               zero_s4;
	rng_mode_t          mode_s4;
	logic [DEN_W-1:0]   den_s4;

	// stage 5
	div_req_t           req_s5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1 -> 2 math
	logic [DIM_W-1:0]          wm1, hm1;
	logic [UCOORD_W+DIM_W-1:0] x_prod, y_prod;

	assign wm1    = DIM_W'(w_s1 - DIMV_W'(1));
	assign hm1    = DIM_W'(h_s1 - DIMV_W'(1));
	assign x_prod = (UCOORD_W+DIM_W)'(cx_s1) * (UCOORD_W+DIM_W)'(wm1);
	assign y_prod = (UCOORD_W+DIM_W)'(cy_s1) * (UCOORD_W+DIM_W)'(hm1);

	// stage 2 -> 3 math
	logic [ADDR_W-1:0] addr_c;
	rng_mode_t         mode_c;
	logic [DEN_W-1:0]  den_c;

	assign addr_c = ADDR_W'(y_s2) * ADDR_W'(w_s2) + ADDR_W'(x_s2);

	always_comb begin
		if (sge_s2) begin
			mode_c = (ps_s2 >= PS_MIN) ? RNG_PS : RNG_CONST;
		end else begin
			mode_c = (p_s2 >= PR_MIN) ? RNG_P : RNG_CONST;
		end
		case (mode_c)
			RNG_PS:  den_c = (DEN_W'(ps_s2) << 9) - (DEN_W'(ps_s2) << 1);
			RNG_P:   den_c = (DEN_W'(p_s2) << 9) - (DEN_W'(p_s2) << 1);
			default: den_c = DEN_CONST;
		endcase
	end

	// stage 4 -> 5 math
	logic [CH_W-1:0]  med;
	logic             neg_c;
	logic [CH_W-1:0]  k_c;
	logic [NUM_W-1:0] num_c;

	always_comb begin
		med   = median3(rdata[23:16], rdata[15:8], rdata[7:0]);
		neg_c = !med[CH_W-1];
		k_c   = neg_c ? (CH_W'(255) - {med[CH_W-2:0], 1'b0})
		              : ({med[CH_W-2:0], 1'b0} - CH_W'(255));
		case (mode_s4)
			RNG_PS:  num_c = NUM_W'(k_c) << NUM_A_SH;
			RNG_P:   num_c = NUM_W'(k_c) * NUM_C;
			default: num_c = NUM_W'(k_c) * NUM_B;
		endcase
	end

	// a write item leaving stage 3
	logic wr_leave;

	assign wr_leave = rdy4 && v_s3 && !act_s3;

	// memory side: writes and reads both happen as items leave stage 3
	always_comb begin
		mem.we    = wr_leave && iok_s3;
		mem.waddr = ADDR_W'(idx_s3);
		mem.wdata = rgb_s3;
		mem.re    = rdy4;
		mem.raddr = addr_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3 && act_s3;  // writes end here
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			act_s1  <= in_action;
			zero_s1 <= !cfg.ready;
			idx_s1  <= f_idx;
			rgb_s1  <= f_rgb;
			cx_s1   <= clamp_coord(f_cx);
			cy_s1   <= clamp_coord(f_cy);
			sr_s1   <= f_sr;
			w_s1    <= dim_sat(cfg.width);
			h_s1    <= dim_sat(cfg.height);
		end
		if (rdy2) begin
			act_s2  <= act_s1;
			zero_s2 <= zero_s1;
			sge_s2  <= sr_s1 >= SR_MIN;
			idx_s2  <= idx_s1;
			rgb_s2  <= rgb_s1;
			w_s2    <= w_s1;
			x_s2    <= x_prod[16 +: DIM_W];
			y_s2    <= y_prod[16 +: DIM_W];
			ps_s2   <= PS_W'(cfg.dist_range) * PS_W'(sr_s1);
			p_s2    <= cfg.dist_range;
		end
		if (rdy3) begin
			act_s3  <= act_s2;
			zero_s3 <= zero_s2;
			iok_s3  <= 32'(idx_s2) < 32'(STORE_DEPTH);
			idx_s3  <= idx_s2;
			rgb_s3  <= rgb_s2;
			addr_s3 <= addr_c;
			mode_s3 <= mode_c;
			den_s3  <= den_c;
		end
		if (rdy4) begin
			zero_s4 <= zero_s3;
			mode_s4 <= mode_s3;
			den_s4  <= den_s3;
		end
		if (rdy5) begin
			req_s5.zero <= zero_s4;
			req_s5.neg  <= neg_c;
			req_s5.num  <= num_c;
			req_s5.den  <= den_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_req   = req_s5;

	`MOS_ASSERT(a_x_in_row, v_s2, DIMV_W'(x_s2) < w_s2, "texel column beyond width")
	`MOS_ASSERT_NEXT(a_write_drops, wr_leave, !v_s4, "write item reached result path")

endmodule

// ===== rtl/core/mos_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, plus final opacity.
`include "assert_macros.svh"
module mos_div
	import mos_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  div_req_t         in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OPA_W-1:0] opacity
);

	logic                rdy   [QUO_W+2];
	logic                v_s   [QUO_W+1];
	logic [NUM_W-1:0]    rem_s [QUO_W+1];
	logic [DEN_W-1:0]    den_s [QUO_W+1];
	logic [QUO_W-1:0]    q_s   [QUO_W+1];
	logic                sat_s [QUO_W+1];
	logic                neg_s [QUO_W+1];
	logic                zero_s[QUO_W+1];

	logic             ovalid_q;
	logic [OPA_W-1:0] opacity_q;

	assign rdy[QUO_W+1] = !ovalid_q || out_ready;
	assign in_ready     = rdy[0];

	for (genvar j = 0; j <= QUO_W; j++) begin : g_rdy
		assign rdy[j] = !v_s[j] || rdy[j+1];
	end

	// stage 0: saturation check, quotient of 2^15 or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rem_s[0]  <= in_req.num;
			den_s[0]  <= in_req.den;
			q_s[0]    <= '0;
			sat_s[0]  <= CMP_W'(in_req.num) >= (CMP_W'(in_req.den) << QUO_W);
			neg_s[0]  <= in_req.neg;
			zero_s[0] <= in_req.zero;
		end
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_step
		localparam int SH = QUO_W - j;
		logic [CMP_W-1:0] dsh, rem_w;
		logic             ge;

		always_comb begin
			dsh   = CMP_W'(den_s[j-1]) << SH;
			rem_w = CMP_W'(rem_s[j-1]);
			ge    = rem_w >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j]) begin
				rem_s[j]  <= ge ? NUM_W'(rem_w - dsh) : rem_s[j-1];
				q_s[j]    <= q_s[j-1] | (ge ? (QUO_W'(1) << SH) : '0);
				den_s[j]  <= den_s[j-1];
				sat_s[j]  <= sat_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	// final: 1/2 plus or minus the quotient, floor above, ceiling below
	logic [OPA_W-1:0] qc, opa_c;

	always_comb begin
		qc = OPA_W'(q_s[QUO_W]) + OPA_W'(|rem_s[QUO_W]);
		if (zero_s[QUO_W]) begin
			opa_c = '0;
		end else if (neg_s[QUO_W]) begin
			opa_c = (sat_s[QUO_W] || qc[OPA_W-1]) ? '0 : (OPA_W'(32768) - qc);
		end else begin
			opa_c = sat_s[QUO_W] ? '1 : {1'b1, q_s[QUO_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (rdy[QUO_W+1]) begin
			ovalid_q <= v_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[QUO_W+1]) begin
			opacity_q <= opa_c;
		end
	end

	assign out_valid = ovalid_q;
	assign opacity   = opacity_q;

	`MOS_ASSERT_NEXT(a_sat_full, rdy[QUO_W+1] && v_s[QUO_W] && sat_s[QUO_W] && !neg_s[QUO_W] && !zero_s[QUO_W], opacity_q == '1, "saturated sample not full opacity")

endmodule

// ===== rtl/core/msdf_opacity_sample.sv =====
// Top level of the signed-distance atlas opacity sampler.
//
//  channel  dir  handshake                  payload
//  s_       in   s_tvalid / s_tready        s_tdata (texel write or sample), s_tuser action
//  m_       out  m_tvalid / m_tready        m_tdata opacity Q0.16
//  apb      in   psel, penable, pwrite      paddr, pwdata, prdata; pready tied high
//
// One item enters per clock when the pipeline is flowing. A sample's result reaches m_
// through 22 register stages after its s_ transfer: five front stages (clamp,
// scale, address and range setup, texel read, median), a 16-stage restoring divider
// (saturation check, then one quotient bit per stage) and the output register.
// Writes take effect as they pass the texel read stage and give no result. Stages
// with no item accept even while the output waits, so bubbles close up under a stall.
// Reset clears the stage valid bits and the configuration registers; the texel store
// is not cleared.
`include "assert_macros.svh"
module msdf_opacity_sample
	import mos_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [17:0] texel_index, [25:18] texel_red, [33:26] texel_green,
	// [41:34] texel_blue, [59:42] coord_x, [77:60] coord_y, [101:78] screen_range
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] action
	input  logic                 s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [15:0] opacity
	output logic [M_TDATA_W-1:0] m_tdata,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [PR_W-1:0]      dist_range_q;
	logic [CFG_DIM_W-1:0] width_q, height_q;
	logic                 ready_q;
	cfg_reg_t             reg_sel;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_range_q <= PR_W'(1024);
			width_q      <= CFG_DIM_W'(512);
			height_q     <= CFG_DIM_W'(512);
			ready_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_DIST_RANGE:  dist_range_q <= pwdata[PR_W-1:0];
				REG_TEX_WIDTH:   width_q      <= pwdata[CFG_DIM_W-1:0];
				REG_TEX_HEIGHT:  height_q     <= pwdata[CFG_DIM_W-1:0];
				REG_ATLAS_READY: ready_q      <= pwdata[0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DIST_RANGE:  prdata = 32'(dist_range_q);
			REG_TEX_WIDTH:   prdata = 32'(width_q);
			REG_TEX_HEIGHT:  prdata = 32'(height_q);
			REG_ATLAS_READY: prdata = 32'(ready_q);
			default:         prdata = '0;
		endcase
	end

	cfg_t cfg;
	assign cfg = '{dist_range: dist_range_q, width: width_q, height: height_q,
	               ready: ready_q};

	// front -> divider
	mem_req_t           mem;
	logic [TEXEL_W-1:0] rdata;
	logic               div_valid, div_ready;
	div_req_t           div_req;
	logic [OPA_W-1:0]   opacity;

	mos_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_action (s_tuser),
		.cfg       (cfg),
		.mem       (mem),
		.rdata     (rdata),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_req   (div_req)
	);

	mos_store u_store (
		.clk   (clk),
		.req   (mem),
		.rdata (rdata)
	);

	mos_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_req    (div_req),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.opacity   (opacity)
	);

	assign m_tdata = opacity;

	// an empty output register means nothing downstream can hold the input off
	`MOS_ASSERT(a_empty_accepts, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

// ===== test/msdf_opacity_sample_tb.sv =====
// Testbench for the signed-distance atlas opacity sampler: self-checking stream test.
`timescale 1ns / 1ps
module msdf_opacity_sample_tb
	import mos_pkg::*;
();

	localparam int DEPTH = 262144;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [3:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	msdf_opacity_sample DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one input transfer: action goes on tuser, the rest packed into tdata
	typedef struct {
		logic                 action;
		logic [S_TDATA_W-1:0] payload;
	} stream_word_t;

	stream_word_t    word_q[$];      // items waiting for the driver
	logic [15:0]     opacity_q[$];   // predicted opacities, oldest first
	int              fails = 0;
	int              results_seen = 0;
	int              queued_cnt = 0;  // items queued so far

	// predictor's view of the block
	logic [23:0]     texel_mem [DEPTH];
	bit              texel_valid [DEPTH];
	logic [15:0]     cur_dist_range = 16'd1024;
	logic [9:0]      cur_width = 10'd512;
	logic [9:0]      cur_height = 10'd512;
	logic            cur_ready = 1'b0;

	// idling control
	bit              sender_busy_mode = 1'b1;
	bit              receiver_busy_mode = 1'b1;
	bit              hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned dim_clip(logic [9:0] v);
		if (v == 0) return 1;
		if (v > ATLAS_DIM) return ATLAS_DIM;
		return v;
	endfunction

	// signed Q2.16 -> texel column/row, truncating
	function automatic int unsigned texel_pos(logic [17:0] raw, int unsigned dim);
		longint c;
		c = $signed(raw);
		if (c < 0) c = 0;
		if (c > 65536) c = 65536;
		return 32'((c * (dim - 1)) >> 16);
	endfunction

	function automatic int unsigned mid_of3(int unsigned a, int unsigned b, int unsigned c);
		int unsigned lo, hi, t;
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		t  = hi < c ? hi : c;
		return lo > t ? lo : t;
	endfunction

	// exact rational evaluation of clamp((m/255-0.5)/range+0.5, 0, 1) in Q0.16
	function automatic logic [15:0] coverage(longint unsigned m, longint unsigned p,
			longint unsigned s);
		longint unsigned rn, rd, den, num, q;
		if (s * 1000 >= 4096) begin
			if (p * s * 1000 >= (64'd1 << 24)) begin
				rn = p * s;
				rd = 64'd1 << 24;
			end else begin
				rn = 1;
				rd = 1000;
			end
		end else if (p >= 4096) begin
			rn = p;
			rd = 4096000;
		end else begin
			rn = 1;
			rd = 1000;
		end
		den = 510 * rn;
		if (2 * m >= 255) begin
			num = 65536 * (2 * m - 255) * rd;
			q = 32768 + num / den;
			return q > 65535 ? 16'hFFFF : q[15:0];
		end
		num = 65536 * (255 - 2 * m) * rd;
		q = (num + den - 1) / den;
		if (q >= 32768) return 16'd0;
		return 16'(32768 - q);
	endfunction

	task automatic push_texel(logic [17:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		stream_word_t w;
		w.action  = 1'b0;
		w.payload = '0;
		w.payload[17:0]   = idx;
		w.payload[25:18]  = r;
		w.payload[33:26]  = g;
		w.payload[41:34]  = b;
		// unused sample fields carry noise
		w.payload[59:42]  = 18'($urandom);
		w.payload[77:60]  = 18'($urandom);
		w.payload[101:78] = 24'($urandom);
		word_q.push_back(w);
		queued_cnt++;
		texel_mem[idx]   = {r, g, b};
		texel_valid[idx] = 1'b1;
	endtask

	// queues a sample; a texel it would read that was never written gets written first
	task automatic push_sample(logic [17:0] cx, logic [17:0] cy, logic [23:0] sr);
		stream_word_t w;
		int unsigned wd, ht, addr;
		logic [23:0] t;
		wd = dim_clip(cur_width);
		ht = dim_clip(cur_height);
		addr = texel_pos(cy, ht) * wd + texel_pos(cx, wd);
		if (cur_ready && !texel_valid[addr])
			push_texel(18'(addr), 8'($urandom), 8'($urandom), 8'($urandom));
		w.action  = 1'b1;
		w.payload = '0;
		w.payload[17:0]   = 18'($urandom);
		w.payload[41:18]  = 24'($urandom);
		w.payload[59:42]  = cx;
		w.payload[77:60]  = cy;
		w.payload[101:78] = sr;
		word_q.push_back(w);
		queued_cnt++;
		if (!cur_ready) begin
			opacity_q.push_back(16'd0);
		end else begin
			t = texel_mem[addr];
			opacity_q.push_back(coverage(mid_of3(t[23:16], t[15:8], t[7:0]),
				cur_dist_range, sr));
		end
	endtask

	task automatic apb_write(cfg_reg_t sel, logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (sel)
			REG_DIST_RANGE:  cur_dist_range = v[15:0];
			REG_TEX_WIDTH:   cur_width = v[9:0];
			REG_TEX_HEIGHT:  cur_height = v[9:0];
			REG_ATLAS_READY: cur_ready = v[0];
			default:         ;
		endcase
	endtask

	task automatic set_config(logic [15:0] pr, logic [9:0] wd, logic [9:0] ht, logic rdy);
		apb_write(REG_DIST_RANGE, {16'h0, pr});
		apb_write(REG_TEX_WIDTH, {22'h0, wd});
		apb_write(REG_TEX_HEIGHT, {22'h0, ht});
		apb_write(REG_ATLAS_READY, {31'h0, rdy});
	endtask

	// drain everything, then cover the pipeline depth since writes leave no result
	task automatic wait_idle();
		while (word_q.size() != 0 || s_tvalid || opacity_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [17:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return 18'($urandom);
			1:       return 18'h10000;
			2:       return 18'h0;
			default: return 18'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [23:0] rand_screen();
		case ($urandom_range(0, 7))
			0:       return 24'($urandom);
			1:       return 24'($urandom_range(0, 8));
			default: return 24'($urandom_range(1024, 65536));
		endcase
	endfunction

	// queues about n items, texel writes added ahead of samples included
	task automatic random_burst(int n);
		int stop;
		stop = queued_cnt + n;
		while (queued_cnt < stop) begin
			if ($urandom_range(0, 3) == 0)
				push_texel(18'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			else
				push_sample(rand_coord(), rand_coord(), rand_screen());
		end
	endtask

	// stimulus and phase sequencing
	initial begin
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not ready after reset: samples read as zero, writes still land
		push_texel(18'h0, 8'd0, 8'd0, 8'd0);
		push_texel(18'h3FFFF, 8'd255, 8'd255, 8'd255);
		push_sample(18'h20000, 18'h1FFFF, 24'hFFFFFF);
		push_sample(18'h0, 18'h0, 24'h0);
		wait_idle();

		// directed: default ranges, full atlas, corners and median edges
		set_config(16'd1024, 10'd512, 10'd512, 1'b1);
		push_texel(18'h0, 8'd128, 8'd127, 8'd200);
		push_texel(18'd511, 8'd127, 8'd127, 8'd128);
		push_texel(18'h3FE00, 8'd0, 8'd255, 8'd128);
		push_sample(18'h20000, 18'h20000, 24'd4096);   // clamps to texel 0
		push_sample(18'h1FFFF, 18'h0, 24'd4096);       // clamps to right edge
		push_sample(18'h0, 18'h10000, 24'd4096);
		push_sample(18'h10000, 18'h10000, 24'h0);      // tiny screen range
		push_sample(18'hFFFF, 18'hFFFF, 24'd5);
		push_sample(18'h0, 18'h0, 24'd4);
		push_sample(18'h0, 18'h0, 24'hFFFFFF);
		push_sample(18'h0, 18'h0, 24'd1);
		wait_idle();

		// zero pixel range and zero dimensions
		set_config(16'd0, 10'd0, 10'd0, 1'b1);
		push_sample(18'h8000, 18'h8000, 24'd4096);
		push_sample(18'h0, 18'h0, 24'h0);
		push_sample(18'h1FFFF, 18'h1FFFF, 24'hFFFFFF);
		wait_idle();

		// widest settings: dimensions above the atlas saturate
		set_config(16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
		push_sample(18'h10000, 18'h10000, 24'h0);
		push_sample(18'h10000, 18'h0, 24'hFFFFFF);
		push_sample(18'h4000, 18'hC000, 24'd2);
		wait_idle();

		// random phases under assorted settings
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_config(16'd1024, 10'd512, 10'd512, 1'b1);
				1: set_config(16'd1, 10'd1, 10'd512, 1'b1);
				2: set_config(16'd256, 10'd3, 10'd5, 1'b1);
				3: set_config(16'($urandom), 10'($urandom), 10'($urandom), 1'b0);
				4: set_config(16'hFFFF, 10'd512, 10'd1, 1'b1);
				default: set_config(16'($urandom), 10'($urandom_range(1, 1023)),
					10'($urandom_range(1, 1023)), 1'b1);
			endcase
			random_burst(ph == 0 ? 250 : 110);
			wait_idle();
		end

		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// sender: one gap draw per item, with calm stretches
	int unsigned send_gap = 0;
	int          sent_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser  <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (word_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= word_q[0].action;
				s_tdata  <= word_q[0].payload;
				void'(word_q.pop_front());
				sent_cnt <= sent_cnt + 1;
				if (sent_cnt % 150 == 0)
					sender_busy_mode <= $urandom_range(0, 2) != 0;
				send_gap <= sender_busy_mode ? $urandom_range(0, 8) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: per-result stall draw, plus one long hold-off to back the pipe up
	int unsigned stall_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_cnt <= 0;
		end else if (!hold_done && results_seen == 40) begin
			hold_done <= 1'b1;
			stall_cnt <= 400;
			m_tready  <= 1'b0;
		end else if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready  <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			if (results_seen % 120 == 0)
				receiver_busy_mode <= $urandom_range(0, 2) != 0;
			stall_cnt <= receiver_busy_mode ? $urandom_range(0, 8) : 0;
			m_tready  <= !receiver_busy_mode;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (opacity_q.size() == 0) begin
				$error("unexpected transfer: opacity %0d", m_tdata);
				fails++;
			end else begin
				if (m_tdata !== opacity_q[0]) begin
					$error("opacity: expected %0d, got %0d", opacity_q[0], m_tdata);
					fails++;
				end
				void'(opacity_q.pop_front());
			end
		end
	end

endmodule
